@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the voxel ray traversal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the given reset is high.
`define VRT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("voxel ray traversal: same-cycle check failed");

// Next-cycle implication, disabled while the given reset is high.
`define VRT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("voxel ray traversal: next-cycle check failed");

`endif

@@ rtl/vrt_pkg.sv @@
// Types, constants and codes shared by the voxel ray traversal block.
package vrt_pkg;

  localparam int FRAC_BITS_DEF  = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int DIR_ONE_BITS   = 14;
  localparam int T_BITS         = 32;
  localparam int OUT_BITS       = 16;

  localparam logic [T_BITS-1:0] T_SAT = {T_BITS{1'b1}};

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [1:0] STATUS_QUERY = 2'd0;
  localparam logic [1:0] STATUS_HIT   = 2'd1;
  localparam logic [1:0] STATUS_MISS  = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_SELECT,
    S_ADVANCE,
    S_RESULT
  } vrt_state_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        max_distance;
    logic               is_solid;
  } vrt_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic signed [15:0] adjacent_x;
    logic signed [15:0] adjacent_y;
    logic signed [15:0] adjacent_z;
  } vrt_rsp_t;

endpackage

@@ rtl/vrt_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module vrt_divider import vrt_pkg::*; #(
  parameter int DIVIDEND_BITS = FRAC_BITS_DEF + DIR_ONE_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [15:0]              divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS);

  logic [15:0]                rem;
  logic [DIVIDEND_BITS-1:0]   shreg;
  logic [15:0]                dvs;
  logic [CNT_BITS-1:0]        cnt;
  logic                       busy;
  logic [16:0]                trial;
  logic                       fits;
  logic [16:0]                diff;
  logic                       last;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem, shreg[DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};
  assign last  = cnt == CNT_BITS'(DIVIDEND_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (busy) begin
      rem   <= fits ? diff[15:0] : trial[15:0];
      shreg <= {shreg[DIVIDEND_BITS-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

@@ rtl/voxel_ray_traversal.sv @@
// Top level of the voxel ray traversal block: control, axis state and result register.
//
// Use: the requester sends transactions on req (req_valid, req_stall, req_data).
// A start transaction (kind 0) loads a ray; the block floors the origin to a
// voxel and forms the per-axis crossing distances with a bit-serial divider,
// six divisions of FRAC_BITS+15 quotient bits each; the first query follows
// the last division through the result state and the output register.
// An answer transaction (kind 1) reports whether the last queried voxel is
// solid. A solid answer gives a hit result through the result state and the
// output register; otherwise the block picks the axis with the nearest
// crossing in the select state, then steps it and checks the distance limit
// in the advance state, and the query or miss result follows through the
// result state and the output register.
// An answer that arrives with no ray in flight is consumed and gives no result.
// Each result leaves on rsp (rsp_valid, rsp_stall, rsp_data) from an output
// register; the block takes the next request while a result is held there, and
// only waits before loading a new result while the receiver stalls the old one.
// Reset (rst, synchronous) empties the output register and drops any ray.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  vrt_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output vrt_rsp_t rsp_data
);

  localparam int DW = FRAC_BITS + DIR_ONE_BITS + 1;
  localparam logic [DW-1:0] DELTA_NUM = {1'b1, {(DW-1){1'b0}}};

  vrt_state_t state;
  vrt_state_t state_next;

  // Per-axis ray state.
  logic signed [COORD_BITS-1:0] cur_voxel [3];
  logic signed [COORD_BITS-1:0] prev_voxel [3];
  logic                         step_neg [3];
  logic [T_BITS-1:0]            t_delta [3];
  logic [T_BITS-1:0]            t_next [3];
  logic [15:0]                  dist_limit;
  logic                         ray_active;

  // The start transaction is held while its divisions run.
  vrt_req_t req_q;
  logic [1:0]  job_axis;
  logic        job_bnd;
  logic [1:0]  sel_ax;
  logic [1:0]  res_status;

  logic req_fire;
  logic div_start;
  logic div_done;
  logic out_load;
  logic job_last;

  logic signed [23:0] org_in [3];
  logic signed [15:0] dir_in [3];
  logic signed [23:0] org_q [3];
  logic signed [15:0] dir_q [3];
  logic [15:0]        mag_q [3];
  logic [FRAC_BITS:0] bnd_q [3];
  logic               pos_in [3];

  logic [DW-1:0]      div_dividend;
  logic [DW-1:0]      div_quot;
  logic [T_BITS-1:0]  div_result;
  logic [1:0]         min_ax;
  logic [T_BITS:0]    t_sum;
  logic [T_BITS-1:0]  t_adv;
  logic               is_miss;

  assign org_in[0] = req_data.origin_x;
  assign org_in[1] = req_data.origin_y;
  assign org_in[2] = req_data.origin_z;
  assign dir_in[0] = req_data.dir_x;
  assign dir_in[1] = req_data.dir_y;
  assign dir_in[2] = req_data.dir_z;
  assign org_q[0]  = req_q.origin_x;
  assign org_q[1]  = req_q.origin_y;
  assign org_q[2]  = req_q.origin_z;
  assign dir_q[0]  = req_q.dir_x;
  assign dir_q[1]  = req_q.dir_y;
  assign dir_q[2]  = req_q.dir_z;

  // A zero component steps negative; its crossings saturate further below.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_in[i] = !dir_in[i][15] && (dir_in[i] != '0);
      mag_q[i]  = dir_q[i][15] ? 16'(-dir_q[i]) : 16'(dir_q[i]);
      if (!dir_q[i][15] && (dir_q[i] != '0)) begin
        bnd_q[i] = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, org_q[i][FRAC_BITS-1:0]};
      end else begin
        bnd_q[i] = {1'b0, org_q[i][FRAC_BITS-1:0]};
      end
    end
  end

  // Job order: delta then first crossing, for x, y and z.
  assign div_dividend = job_bnd ? {bnd_q[job_axis], {DIR_ONE_BITS{1'b0}}} : DELTA_NUM;
  assign div_result   = (mag_q[job_axis] == '0) ? T_SAT : T_BITS'(div_quot);
  assign job_last     = job_bnd && (job_axis == AXIS_Z);

  vrt_divider #(
    .DIVIDEND_BITS(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (mag_q[job_axis]),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Nearest crossing; ties go to z, then y.
  always_comb begin
    if (t_next[0] < t_next[1] && t_next[0] < t_next[2]) begin
      min_ax = AXIS_X;
    end else if (t_next[1] < t_next[2]) begin
      min_ax = AXIS_Y;
    end else begin
      min_ax = AXIS_Z;
    end
  end

  assign t_sum   = {1'b0, t_next[sel_ax]} + {1'b0, t_delta[sel_ax]};
  assign t_adv   = t_sum[T_BITS] ? T_SAT : t_sum[T_BITS-1:0];
  assign is_miss = t_next[sel_ax] > {{(T_BITS-16){1'b0}}, dist_limit};

  assign req_fire = req_valid && !req_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req_data.kind == KIND_START) begin
            state_next = S_DIV_START;
          end else if (ray_active) begin
            state_next = req_data.is_solid ? S_RESULT : S_SELECT;
          end
        end
      end
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = job_last ? S_RESULT : S_DIV_START;
        end
      end
      S_SELECT:  state_next = S_ADVANCE;
      S_ADVANCE: state_next = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = state != S_IDLE;
    div_start = state == S_DIV_START;
    out_load  = (state == S_RESULT) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ray_active <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && req_data.kind == KIND_START) begin
        ray_active <= 1'b1;
      end else if (req_fire && req_data.is_solid) begin
        ray_active <= 1'b0;
      end else if (state == S_ADVANCE && is_miss) begin
        ray_active <= 1'b0;
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req_data.kind == KIND_START) begin
      req_q      <= req_data;
      dist_limit <= req_data.max_distance;
      job_axis   <= AXIS_X;
      job_bnd    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur_voxel[i]  <= COORD_BITS'(org_in[i] >>> FRAC_BITS);
        prev_voxel[i] <= COORD_BITS'(org_in[i] >>> FRAC_BITS);
        step_neg[i]   <= !pos_in[i];
      end
    end
    if (req_fire && req_data.kind == KIND_ANSWER) begin
      res_status <= STATUS_HIT;
    end
    if (state == S_DIV_WAIT && div_done) begin
      if (job_bnd) begin
        t_next[job_axis] <= div_result;
        job_axis         <= job_axis + 1'b1;
      end else begin
        t_delta[job_axis] <= div_result;
      end
      job_bnd    <= !job_bnd;
      res_status <= STATUS_QUERY;
    end
    if (state == S_SELECT) begin
      sel_ax <= min_ax;
    end
    if (state == S_ADVANCE) begin
      for (int i = 0; i < 3; i++) begin
        prev_voxel[i] <= cur_voxel[i];
      end
      cur_voxel[sel_ax] <= step_neg[sel_ax] ? cur_voxel[sel_ax] - 1'b1
                                            : cur_voxel[sel_ax] + 1'b1;
      t_next[sel_ax]    <= t_adv;
      res_status        <= is_miss ? STATUS_MISS : STATUS_QUERY;
    end
  end

  // Output register; a miss carries zero coordinates.
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_data.status <= res_status;
      if (res_status == STATUS_MISS) begin
        rsp_data.voxel_x    <= '0;
        rsp_data.voxel_y    <= '0;
        rsp_data.voxel_z    <= '0;
        rsp_data.adjacent_x <= '0;
        rsp_data.adjacent_y <= '0;
        rsp_data.adjacent_z <= '0;
      end else begin
        rsp_data.voxel_x    <= OUT_BITS'(cur_voxel[0]);
        rsp_data.voxel_y    <= OUT_BITS'(cur_voxel[1]);
        rsp_data.voxel_z    <= OUT_BITS'(cur_voxel[2]);
        rsp_data.adjacent_x <= OUT_BITS'(prev_voxel[0]);
        rsp_data.adjacent_y <= OUT_BITS'(prev_voxel[1]);
        rsp_data.adjacent_z <= OUT_BITS'(prev_voxel[2]);
      end
    end
  end

endmodule

@@ rtl/vrt_checker.sv @@
// Port-level checker for the voxel ray traversal block and its bind.
`include "assert_macros.svh"

module vrt_checker import vrt_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input vrt_rsp_t rsp_data
);

  // A stalled result stays offered.
  `VRT_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)

  // A stalled result keeps its payload.
  `VRT_ASSERT_NXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp_data))

  // A miss result carries zero coordinates.
  `VRT_ASSERT_IMP(a_miss_zero, clk, rst, rsp_valid && rsp_data.status == STATUS_MISS, rsp_data.voxel_x == '0 && rsp_data.voxel_y == '0 && rsp_data.voxel_z == '0 && rsp_data.adjacent_x == '0 && rsp_data.adjacent_y == '0 && rsp_data.adjacent_z == '0)

  // Reset empties the output register.
  `VRT_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !rsp_valid)

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
